>>> rtl/i2crp_pkg.sv
// Package for the I2C register pointer slave: defaults, register codes, reply type.
package i2crp_pkg;

   localparam int NUM_REGS_DEFAULT            = 11;
   localparam int CONTROL_REG_INDEX_DEFAULT   = 5;
   localparam int SEQ_DISABLE_BIT_DEFAULT     = 5;
   localparam int DIRECTION_REG_INDEX_DEFAULT = 0;

   localparam logic [7:0] DIRECTION_RESET = 8'hFF;
   localparam logic [7:0] ACK_DATA        = 8'h01;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_MASK  = 8'd1;

   // reply queue: one item makes at most three replies
   localparam int MAX_REPLIES = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       is_data;
      logic [7:0] address;
      logic [7:0] data;
      logic       last;
   } reply_type;

endpackage

>>> rtl/i2c_register_pointer_slave.sv
// Top level: I2C slave register file with auto-incrementing register pointer.
//
// One bus event per req transfer (stop, start, write, read flags in any mix,
// handled in that order). All state updates for an event are done in the
// cycle it is taken; its zero to three replies (start ack, write ack, read
// data) go into a four-entry reply queue and leave one per cycle on rsp unless
// stalled, the final one of an event flagged by rsp_last. An event is taken in
// every cycle while the queue holds at most one reply, so events that cause
// one reply or none run at one per cycle unless rsp stalls; an event with
// several replies sends them in turn, so rsp sets the sustained rate. The
// register file lives in flip-flops and comes out of reset with the direction
// register at 0xFF and all others zero. csr_ready is always high; csr index 0
// is the slave address, 1 the address mask, other indexes are ignored.
module i2c_register_pointer_slave
   import i2crp_pkg::*;
#(
   parameter int NUM_REGS            = NUM_REGS_DEFAULT,
   parameter int CONTROL_REG_INDEX   = CONTROL_REG_INDEX_DEFAULT,
   parameter int SEQ_DISABLE_BIT     = SEQ_DISABLE_BIT_DEFAULT,
   parameter int DIRECTION_REG_INDEX = DIRECTION_REG_INDEX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // bus events
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_is_stop,
   input  logic                   req_is_start,
   input  logic                   req_is_write,
   input  logic                   req_is_read,
   input  logic [7:0]             req_bus_address,
   input  logic [7:0]             req_data_byte,
   // replies
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_reply_is_data,
   output logic [7:0]             rsp_reply_address,
   output logic [7:0]             rsp_reply_data,
   output logic                   rsp_last,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [8:0] NUM_REGS_9 = 9'(NUM_REGS);
   // control / direction registers may sit outside the file
   localparam bit CTRL_IN_FILE = (CONTROL_REG_INDEX < NUM_REGS);
   localparam bit DIR_IN_FILE  = (DIRECTION_REG_INDEX < NUM_REGS);
   localparam int CTRL_IDX     = CTRL_IN_FILE ? CONTROL_REG_INDEX : 0;
   localparam int SEQ_BIT      = SEQ_DISABLE_BIT & 7;

   // configuration registers
   logic [7:0] slave_address_ff, address_mask_ff;

   // slave state
   logic [7:0] selected_ff,  selected_in;
   logic       loaded_ff,    loaded_in;
   logic [7:0] pointer_ff,   pointer_in;
   logic [7:0] regs_ff [NUM_REGS];
   logic [7:0] regs_in [NUM_REGS];

   // reply queue, slot 0 is the head
   reply_type              queue_ff [QUEUE_DEPTH];
   reply_type              queue_in [QUEUE_DEPTH];
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   logic req_take, rsp_take;

   assign req_stall = (count_ff > QUEUE_CNT_W'(1));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_reply_is_data = queue_ff[0].is_data;
   assign rsp_reply_address = queue_ff[0].address;
   assign rsp_reply_data    = queue_ff[0].data;
   assign rsp_last          = queue_ff[0].last;

   // pointer step: wraps to 0 at the end of the file, also from out of range; holds when hold is set
   function automatic logic [7:0] next_pointer(input logic [7:0] ptr, input logic hold);
      logic [8:0] inc;
      inc = {1'b0, ptr} + 9'd1;
      if (hold)
         return ptr;
      else if (inc >= NUM_REGS_9)
         return 8'd0;
      else
         return inc[7:0];
   endfunction

   // ---------------------------------------------------------------------
   // event evaluation
   // ---------------------------------------------------------------------
   logic       match, active, do_write, do_read, store_en, seq_hold;
   logic [7:0] sel_a, ptr_a, ptr_b, ptr_c, read_value, keep;
   logic       loaded_a;
   reply_type  start_rep, write_rep, read_rep;
   reply_type  replies [MAX_REPLIES];
   logic [1:0] num_replies;

   always_comb begin
      keep  = ~address_mask_ff;
      match = ((slave_address_ff & keep) == (req_bus_address & keep));

      // stop, then start
      sel_a    = req_is_stop ? 8'd0 : selected_ff;
      ptr_a    = req_is_stop ? 8'd0 : pointer_ff;
      loaded_a = (req_is_stop || req_is_start) ? 1'b0 : loaded_ff;
      if (req_is_start)
         sel_a = match ? req_bus_address : 8'd0;

      // a selected address of zero counts as deselected
      active   = (sel_a != 8'd0);
      do_write = active && req_is_write;
      do_read  = active && req_is_read;
      store_en = do_write && loaded_a && ({1'b0, ptr_a} < NUM_REGS_9);

      for (int k = 0; k < NUM_REGS; k++) begin
         regs_in[k] = (store_en && (ptr_a == 8'(k))) ? req_data_byte : regs_ff[k];
      end

      // sequential-disable sees the file after this event's write
      seq_hold = CTRL_IN_FILE && regs_in[CTRL_IDX][SEQ_BIT];

      ptr_b = ptr_a;
      if (do_write)
         ptr_b = loaded_a ? next_pointer(ptr_a, seq_hold) : req_data_byte;

      read_value = 8'd0;
      if ({1'b0, ptr_b} < NUM_REGS_9)
         read_value = regs_in[ptr_b[IDX_W-1:0]];
      ptr_c = do_read ? next_pointer(ptr_b, seq_hold) : ptr_b;

      selected_in = sel_a;
      pointer_in  = ptr_c;
      loaded_in   = loaded_a || do_write || do_read;

      start_rep  = '{is_data: 1'b0, address: req_bus_address, data: ACK_DATA, last: 1'b0};
      write_rep  = '{is_data: 1'b0, address: sel_a, data: ACK_DATA, last: 1'b0};
      read_rep   = '{is_data: 1'b1, address: sel_a, data: read_value, last: 1'b0};

      // pack the replies in order
      for (int k = 0; k < MAX_REPLIES; k++) begin
         replies[k] = read_rep;
      end
      num_replies = 2'd0;
      if (req_is_start && match) begin
         replies[num_replies] = start_rep;
         num_replies          = num_replies + 2'd1;
      end
      if (do_write) begin
         replies[num_replies] = write_rep;
         num_replies          = num_replies + 2'd1;
      end
      if (do_read) begin
         replies[num_replies] = read_rep;
         num_replies          = num_replies + 2'd1;
      end
      if (num_replies != 2'd0)
         replies[num_replies - 2'd1].last = 1'b1;
   end

   // ---------------------------------------------------------------------
   // reply queue: shift on pop, append behind what stays
   // ---------------------------------------------------------------------
   logic [QUEUE_CNT_W-1:0] base, push_cnt;
   logic [QUEUE_CNT_W-1:0] offset;

   always_comb begin
      base     = count_ff - QUEUE_CNT_W'(rsp_take);
      push_cnt = req_take ? QUEUE_CNT_W'(num_replies) : '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         offset = QUEUE_CNT_W'(k) - base;
         if (rsp_take && (k < QUEUE_DEPTH - 1))
            queue_in[k] = queue_ff[k + 1];
         else
            queue_in[k] = queue_ff[k];
         if ((QUEUE_CNT_W'(k) >= base) && (offset < push_cnt))
            queue_in[k] = replies[offset[1:0]];
      end
      count_in = base + push_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd0;
         address_mask_ff  <= 8'd0;
         selected_ff      <= 8'd0;
         loaded_ff        <= 1'b0;
         pointer_ff       <= 8'd0;
         count_ff         <= '0;
         for (int k = 0; k < NUM_REGS; k++) begin
            regs_ff[k] <= (DIR_IN_FILE && (k == DIRECTION_REG_INDEX)) ? DIRECTION_RESET : 8'd0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SLAVE_ADDRESS)
               slave_address_ff <= csr_data;
            else if (csr_index == CSR_ADDRESS_MASK)
               address_mask_ff <= csr_data;
         end
         if (req_take) begin
            selected_ff <= selected_in;
            loaded_ff   <= loaded_in;
            pointer_ff  <= pointer_in;
            regs_ff     <= regs_in;
         end
         count_ff <= count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("reply queue overflow");

   // replies of one event stay together: a non-final head has its successor queued
   a_group_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> count_ff >= QUEUE_CNT_W'(2))
      else $error("reply group split in queue");

   a_stop_deselect: assert property (@(posedge clock) disable iff (reset)
      req_take && req_is_stop && !req_is_start |=> selected_ff == 8'd0 && pointer_ff == 8'd0)
      else $error("stop did not deselect");

   a_quiet_no_push: assert property (@(posedge clock) disable iff (reset)
      !req_take && !rsp_take |=> count_ff == $past(count_ff))
      else $error("reply queue changed without a transfer");

endmodule
